// ===== rtl/utf8_stream_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// utf8_stream_decoder_defines.svh
// Assertion macros used by the checker file of the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8SD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTF8SD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/utf8sd_pkg.sv =====
// ---------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8sd_pkg;

    // Field widths of the result beat.
    localparam int CP_W  = 31;
    localparam int LEN_W = 3;

    // Bytes held for an open sequence (lead plus up to four continuations).
    localparam int HOLD_DEPTH = 5;
    // Raw bytes one input byte can flush: the held bytes plus a new lead.
    localparam int FLUSH_MAX  = 6;

    // Default depth of the queue between front and back.
    localparam int FIFO_DEPTH = 4;

    // Length of a single-byte result.
    localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;

    typedef logic [7:0] oct_t;

    // One queued command: raw bytes to flush first, then an optional tail.
    typedef struct packed {
        oct_t [FLUSH_MAX-1:0] flush_bytes;
        logic [2:0]           flush_cnt;
        logic                 has_tail;
        logic [CP_W-1:0]      tail_cp;
        logic [LEN_W-1:0]     tail_len;
        logic                 tail_raw;
    } cmd_t;

endpackage

// ===== rtl/utf8sd_front.sv =====
// ---------------------------------------------------------------------------
// utf8sd_front
// Accepts bytes, tracks the open sequence and builds at most one command per byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8sd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_ready,
    input  utf8sd_pkg::oct_t    in_byte,
    input  logic                in_end,
    output logic                cmd_push,
    output utf8sd_pkg::cmd_t    cmd
);

    logic [2:0]       exp_reg,  exp_next;
    logic [2:0]       held_reg, held_next;
    utf8sd_pkg::oct_t pend_reg  [utf8sd_pkg::HOLD_DEPTH];
    utf8sd_pkg::oct_t pend_next [utf8sd_pkg::HOLD_DEPTH];
    utf8sd_pkg::oct_t fb        [utf8sd_pkg::FLUSH_MAX];

    logic       accept;
    logic       seq_open;
    logic       is_cont;
    logic [2:0] lead_n;
    logic [3:0] held_plus;

    // Sequence length announced by a lead byte, zero when it is no lead.
    function automatic logic [2:0] lead_length(input utf8sd_pkg::oct_t b);
        logic [2:0] n;
        n = 3'd0;
        if (b[7:5] == 3'b110)         n = 3'd2;
        else if (b[7:4] == 4'b1110)   n = 3'd3;
        else if (b[7:3] == 5'b11110)  n = 3'd4;
        else if (b[7:2] == 6'b111110) n = 3'd5;
        else if (b[7:1] == 7'b1111110) n = 3'd6;
        return n;
    endfunction

    assign accept    = in_valid && in_ready;
    assign seq_open  = (exp_reg != 3'd0) && (held_reg != 3'd0);
    assign is_cont   = (in_byte[7:6] == 2'b10);
    assign lead_n    = lead_length(in_byte);
    assign held_plus = {1'b0, held_reg} + 4'd1;

    // Classify the byte and decide the command and the next sequence state.
    always_comb begin
        exp_next  = exp_reg;
        held_next = held_reg;
        for (int i = 0; i < utf8sd_pkg::HOLD_DEPTH; i++) begin
            pend_next[i] = pend_reg[i];
            fb[i]        = pend_reg[i];
        end
        fb[utf8sd_pkg::FLUSH_MAX-1] = in_byte;
        cmd.flush_cnt = 3'd0;
        cmd.has_tail  = 1'b0;
        cmd.tail_cp   = '0;
        cmd.tail_len  = utf8sd_pkg::LEN_ONE;
        cmd.tail_raw  = 1'b0;

        if (seq_open && is_cont) begin
            if (held_plus >= {1'b0, exp_reg}) begin
                // Last continuation byte: assemble the code point.
                cmd.has_tail = 1'b1;
                cmd.tail_len = exp_reg;
                unique case (exp_reg)
                    3'd2: cmd.tail_cp = {20'd0, pend_reg[0][4:0], in_byte[5:0]};
                    3'd3: cmd.tail_cp = {15'd0, pend_reg[0][3:0], pend_reg[1][5:0],
                                         in_byte[5:0]};
                    3'd4: cmd.tail_cp = {10'd0, pend_reg[0][2:0], pend_reg[1][5:0],
                                         pend_reg[2][5:0], in_byte[5:0]};
                    3'd5: cmd.tail_cp = {5'd0, pend_reg[0][1:0], pend_reg[1][5:0],
                                         pend_reg[2][5:0], pend_reg[3][5:0],
                                         in_byte[5:0]};
                    3'd6: cmd.tail_cp = {pend_reg[0][0], pend_reg[1][5:0],
                                         pend_reg[2][5:0], pend_reg[3][5:0],
                                         pend_reg[4][5:0], in_byte[5:0]};
                    default: cmd.tail_cp = '0;
                endcase
                exp_next  = 3'd0;
                held_next = 3'd0;
            end else begin
                // Middle continuation byte: hold it, or flush all at stream end.
                pend_next[held_reg] = in_byte;
                held_next           = held_plus[2:0];
                fb[held_reg]        = in_byte;
                if (in_end) begin
                    cmd.flush_cnt = held_plus[2:0];
                    exp_next      = 3'd0;
                    held_next     = 3'd0;
                end
            end
        end else begin
            // A broken sequence flushes its held bytes before the fresh decode.
            cmd.flush_cnt = seq_open ? held_reg : 3'd0;
            exp_next      = 3'd0;
            held_next     = 3'd0;
            if (!in_byte[7]) begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = {23'd0, in_byte};
            end else if (lead_n == 3'd0) begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = {23'd0, in_byte};
                cmd.tail_raw = 1'b1;
            end else begin
                // New lead byte opens a sequence; at stream end it is flushed.
                fb[cmd.flush_cnt] = in_byte;
                if (in_end) begin
                    cmd.flush_cnt = cmd.flush_cnt + 3'd1;
                end else begin
                    pend_next[0] = in_byte;
                    held_next    = 3'd1;
                    exp_next     = lead_n;
                end
            end
        end

        for (int i = 0; i < utf8sd_pkg::FLUSH_MAX; i++) begin
            cmd.flush_bytes[i] = fb[i];
        end
    end

    assign cmd_push = accept && ((cmd.flush_cnt != 3'd0) || cmd.has_tail);

    // Sequence state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg  <= 3'd0;
            held_reg <= 3'd0;
        end else if (accept) begin
            exp_reg  <= exp_next;
            held_reg <= held_next;
        end
    end

    // Held bytes carry no reset; only written entries are ever read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < utf8sd_pkg::HOLD_DEPTH; i++) begin
                pend_reg[i] <= pend_next[i];
            end
        end
    end

endmodule

// ===== rtl/utf8sd_fifo.sv =====
// ---------------------------------------------------------------------------
// utf8sd_fifo
// Small command queue that decouples the front from the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8sd_fifo #(
    parameter int DEPTH = utf8sd_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  utf8sd_pkg::cmd_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output utf8sd_pkg::cmd_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    utf8sd_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/utf8sd_back.sv =====
// ---------------------------------------------------------------------------
// utf8sd_back
// Expands queued commands into result beats through an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8sd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    input  utf8sd_pkg::cmd_t                  cmd,
    output logic                              cmd_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [utf8sd_pkg::CP_W-1:0]       m_code_point,
    output logic [utf8sd_pkg::LEN_W-1:0]      m_seq_length,
    output logic                              m_raw_fallback,
    output logic                              m_final_result
);

    logic [2:0] idx_reg;
    logic       valid_reg;
    logic [2:0] total;
    logic       load;
    logic       last;
    logic       in_flush;

    assign total    = cmd.flush_cnt + {2'b00, cmd.has_tail};
    assign load     = cmd_valid && (!valid_reg || m_ready);
    assign last     = (idx_reg == total - 3'd1);
    assign in_flush = (idx_reg < cmd.flush_cnt);
    assign cmd_pop  = load && last;
    assign m_valid  = valid_reg;

    // Beat index within the head command, and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg <= last ? 3'd0 : idx_reg + 3'd1;
            end
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload: flushed raw bytes first, then the tail result.
    always_ff @(posedge aclk) begin
        if (load) begin
            if (in_flush) begin
                m_code_point   <= {23'd0, cmd.flush_bytes[idx_reg]};
                m_seq_length   <= utf8sd_pkg::LEN_ONE;
                m_raw_fallback <= 1'b1;
            end else begin
                m_code_point   <= cmd.tail_cp;
                m_seq_length   <= cmd.tail_len;
                m_raw_fallback <= cmd.tail_raw;
            end
            m_final_result <= last;
        end
    end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial decoder for the 1-to-6-byte UTF-8 forms with raw fallback.
// ---------------------------------------------------------------------------
// The block takes one byte per beat and gives one result per beat. A byte
// that completes a sequence, or a plain or invalid byte, gives one result;
// a broken or unfinished sequence gives one raw result per held byte, up to
// six results for one byte. Bytes are accepted one per cycle while the
// command queue (FIFO_DEPTH entries) has room, so plain text streams at one
// byte per cycle while m_ready holds; a byte that gives k results keeps the
// output register busy until all k are taken, which sets the rate during raw
// bursts. The first result of a byte passes through the command queue and
// then the output register. No clearing pass follows reset.
`timescale 1ns / 1ps

module utf8_stream_decoder #(
    parameter int FIFO_DEPTH = utf8sd_pkg::FIFO_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_in_byte,
    input  logic                              s_stream_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [utf8sd_pkg::CP_W-1:0]       m_code_point,
    output logic [utf8sd_pkg::LEN_W-1:0]      m_seq_length,
    output logic                              m_raw_fallback,
    output logic                              m_final_result
);

    utf8sd_pkg::cmd_t push_cmd, head_cmd;
    logic             push, full, pop, not_empty;

    assign s_ready = !full;

    // Front: classify bytes and track the open sequence.
    utf8sd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_byte  (s_in_byte),
        .in_end   (s_stream_end),
        .cmd_push (push),
        .cmd      (push_cmd)
    );

    // Command queue.
    utf8sd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head_cmd)
    );

    // Back: emit result beats.
    utf8sd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (not_empty),
        .cmd            (head_cmd),
        .cmd_pop        (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_point   (m_code_point),
        .m_seq_length   (m_seq_length),
        .m_raw_fallback (m_raw_fallback),
        .m_final_result (m_final_result)
    );

endmodule

// ===== rtl/utf8sd_checker.sv =====
// ---------------------------------------------------------------------------
// utf8sd_checker
// Port-level checks on the result channel of the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_stream_decoder_defines.svh"

module utf8sd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [utf8sd_pkg::CP_W-1:0]       m_code_point,
    input logic [utf8sd_pkg::LEN_W-1:0]      m_seq_length,
    input logic                              m_raw_fallback,
    input logic                              m_final_result
);

    // A stalled result beat holds its value.
    `UTF8SD_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_code_point) && $stable(m_final_result), "result beat changed while stalled")

    // A raw byte is a single byte with its top bit set.
    `UTF8SD_ASSERT_NOW(a_raw_byte, aclk, aresetn, m_valid && m_raw_fallback, (m_seq_length == 3'd1) && (m_code_point[30:8] == '0) && m_code_point[7], "malformed raw beat")

    // A decoded result always closes the results of its byte.
    `UTF8SD_ASSERT_NOW(a_decoded_final, aclk, aresetn, m_valid && !m_raw_fallback, m_final_result, "decoded beat not final")

    // A plain single byte decodes below 0x80.
    `UTF8SD_ASSERT_NOW(a_plain_ascii, aclk, aresetn, m_valid && !m_raw_fallback && (m_seq_length == 3'd1), m_code_point[30:7] == '0, "plain byte out of range")

endmodule

bind utf8_stream_decoder utf8sd_checker u_checker (.*);
